// ----- hdl/mbg_pkg.sv -----
package mbg_pkg;

	localparam int CELL_W = 12;
	localparam int MAX_CELLS = 1 << CELL_W;
	localparam int DEPTH_W = CELL_W + 1;
	localparam int DIM_W = 7;
	localparam int COORD_W = 6;
	localparam int MAP_W = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int DIV_STEPS = CELL_W;

	localparam logic [DEPTH_W-1:0] STACK_FULL = {1'b1, {CELL_W{1'b0}}};
	localparam logic [DIM_W-1:0] DIM_MIN = 7'd1;
	localparam logic [DIM_W-1:0] DIM_MAX = 7'd64;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd16;

	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_STEP = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [2:0] MOVE_NORTH = 3'd0;
	localparam logic [2:0] MOVE_EAST = 3'd1;
	localparam logic [2:0] MOVE_SOUTH = 3'd2;
	localparam logic [2:0] MOVE_WEST = 3'd3;
	localparam logic [2:0] MOVE_NONE = 3'd4;

	localparam int BIT_SOUTH = 0;
	localparam int BIT_EAST = 1;
	localparam int BIT_VISITED = 2;

	typedef struct packed {
		logic latch;
		logic start;
		logic rep_read;
		logic rep_ignore;
		logic div_start;
		logic div_step;
		logic rd_issue;
		logic wr1;
		logic wr2;
		logic pop_load;
		logic rep_issue;
		logic out_load;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic active;
		logic coord_ok;
		logic in_grid;
		logic div_last;
		logic rd_last;
		logic clr_last;
		logic pop_next;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/mbg_ram.sv -----
module mbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/mbg_ctrl.sv -----
module mbg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  mbg_pkg::stat_t stat,
	output mbg_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_DIV = 4'd3;
	localparam logic [3:0] S_READ = 4'd4;
	localparam logic [3:0] S_LAST = 4'd5;
	localparam logic [3:0] S_WR1 = 4'd6;
	localparam logic [3:0] S_WR2 = 4'd7;
	localparam logic [3:0] S_POP = 4'd8;
	localparam logic [3:0] S_REPORT = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			init_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR && stat.clr_last) begin
				init_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					// The pass after reset returns to idle; a start reports cell 0.
					state_d = init_q ? S_IDLE : S_REPORT;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.func)
					mbg_pkg::FUNC_START: begin
						cmd.start = 1'b1;
						state_d = S_CLEAR;
					end
					mbg_pkg::FUNC_READ: begin
						cmd.rep_read = 1'b1;
						state_d = S_REPORT;
					end
					mbg_pkg::FUNC_STEP: begin
						if (!stat.active) begin
							cmd.rep_ignore = 1'b1;
							state_d = S_REPORT;
						end else if (stat.in_grid && !stat.coord_ok) begin
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end else begin
							state_d = S_READ;
						end
					end
					default: begin
						cmd.rep_ignore = 1'b1;
						state_d = S_REPORT;
					end
				endcase
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				if (stat.rd_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_WR1;
			end
			S_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = S_WR2;
			end
			S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = stat.pop_next ? S_POP : S_REPORT;
			end
			S_POP: begin
				cmd.pop_load = 1'b1;
				state_d = S_REPORT;
			end
			S_REPORT: begin
				cmd.rep_issue = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign item_stall = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded while the output register is occupied");

	a_pop_after_wr2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> ($past(state_q) == S_WR2))
		else $error("stack pop without a preceding write phase");
`endif

endmodule

// ----- hdl/mbg_dp.sv -----
module mbg_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [mbg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mbg_pkg::DIM_W-1:0]          cfg_data,
	input  logic [1:0]                         func,
	input  logic [7:0]                         rnd,
	input  logic [mbg_pkg::CELL_W-1:0]         addr,
	input  logic                               res_stall,
	output logic                               res_valid,
	output logic [mbg_pkg::CELL_W-1:0]         cell_res,
	output logic [2:0]                         move,
	output logic                               done_res,
	output logic                               south_open,
	output logic                               east_open,
	output logic                               visited,
	output logic                               accepted,
	input  mbg_pkg::cmd_t                      cmd,
	output mbg_pkg::stat_t                     stat
);

	localparam logic [2:0] RD_CUR = 3'd0;
	localparam logic [2:0] RD_NORTH = 3'd1;
	localparam logic [2:0] RD_EAST = 3'd2;
	localparam logic [2:0] RD_SOUTH = 3'd3;
	localparam logic [2:0] RD_WEST = 3'd4;
	localparam logic [3:0] DIV_LAST = 4'(mbg_pkg::DIV_STEPS - 1);

	// Configuration and derived size.
	logic [mbg_pkg::DIM_W-1:0]   grid_w_q, grid_h_q;
	logic [mbg_pkg::DIM_W-1:0]   w_c, h_c;
	logic [2*mbg_pkg::DIM_W-1:0] area_full;
	logic [mbg_pkg::DEPTH_W-1:0] area_q;

	// Latched item.
	logic [1:0]                  func_q;
	logic [7:0]                  rnd_q;
	logic [mbg_pkg::CELL_W-1:0]  addr_q;

	// Walk state.
	logic [mbg_pkg::CELL_W-1:0]  walker_q;
	logic [mbg_pkg::DEPTH_W-1:0] depth_q;
	logic                        active_q, finished_q;
	logic                        coord_ok_q;
	logic [mbg_pkg::COORD_W-1:0] row_q, col_q;

	// Divider.
	logic [mbg_pkg::CELL_W-1:0]  div_quo_q;
	logic [mbg_pkg::COORD_W-1:0] div_rem_q;
	logic [3:0]                  div_cnt_q;
	logic [mbg_pkg::DIM_W-1:0]   div_trial, div_diff;
	logic                        div_ge;
	logic [mbg_pkg::COORD_W-1:0] div_rem_n;
	logic [mbg_pkg::CELL_W-1:0]  div_quo_n;

	// Neighbor gathering.
	logic [mbg_pkg::CELL_W-1:0]  clr_q;
	logic [2:0]                  rd_k_q, rd_slot_q;
	logic                        rd_pend_q;
	logic [mbg_pkg::MAP_W-1:0]   cur_bits_q;
	logic [mbg_pkg::MAP_W-1:0]   nb_bits_q [4];
	logic                        have_move_q;
	logic [1:0]                  pick_q;

	// Report.
	logic [mbg_pkg::CELL_W-1:0]  rep_cell_q;
	logic [2:0]                  rep_move_q;
	logic                        rep_acc_q;

	// Output register.
	logic                        res_valid_q;
	logic [mbg_pkg::CELL_W-1:0]  cell_res_q;
	logic [2:0]                  move_q;
	logic                        done_res_q, south_open_q, east_open_q, visited_q, accepted_q;

	// Memory ports.
	logic                        map_we, map_re;
	logic [mbg_pkg::CELL_W-1:0]  map_waddr, map_raddr;
	logic [mbg_pkg::MAP_W-1:0]   map_wdata, map_rdata;
	logic                        stk_we, stk_re;
	logic [mbg_pkg::CELL_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	// Candidate selection.
	logic [mbg_pkg::CELL_W-1:0]  w12;
	logic [mbg_pkg::DEPTH_W-1:0] walker13, w13;
	logic                        in_grid;
	logic                        ok_n, ok_e, ok_s, ok_w;
	logic [3:0]                  cand;
	logic [2:0]                  n_cand;
	logic [3:0]                  pair_sum;
	logic [1:0]                  mod3;
	logic [1:0]                  pick_idx;
	logic [1:0]                  pick;
	logic                        have_move;
	logic [1:0]                  seen;
	logic [mbg_pkg::CELL_W-1:0]  rd_addr;
	logic [mbg_pkg::CELL_W-1:0]  next_cell;
	logic                        out_free;

	always_comb begin
		if (grid_w_q < mbg_pkg::DIM_MIN) begin
			w_c = mbg_pkg::DIM_MIN;
		end else if (grid_w_q > mbg_pkg::DIM_MAX) begin
			w_c = mbg_pkg::DIM_MAX;
		end else begin
			w_c = grid_w_q;
		end
		if (grid_h_q < mbg_pkg::DIM_MIN) begin
			h_c = mbg_pkg::DIM_MIN;
		end else if (grid_h_q > mbg_pkg::DIM_MAX) begin
			h_c = mbg_pkg::DIM_MAX;
		end else begin
			h_c = grid_h_q;
		end
	end

	// With both sides capped at 64 the area never exceeds the map size.
	assign area_full = w_c * h_c;
	assign w12 = {{(mbg_pkg::CELL_W - mbg_pkg::DIM_W){1'b0}}, w_c};
	assign w13 = {{(mbg_pkg::DEPTH_W - mbg_pkg::DIM_W){1'b0}}, w_c};
	assign walker13 = {1'b0, walker_q};

	// One restoring division step: walker / width gives row and column.
	assign div_trial = {div_rem_q, div_quo_q[mbg_pkg::CELL_W-1]};
	assign div_ge = (div_trial >= w_c);
	assign div_diff = div_trial - w_c;
	assign div_rem_n = div_ge ? div_diff[mbg_pkg::COORD_W-1:0]
		: div_trial[mbg_pkg::COORD_W-1:0];
	assign div_quo_n = {div_quo_q[mbg_pkg::CELL_W-2:0], div_ge};

	always_comb begin
		case (rd_k_q)
			RD_CUR:   rd_addr = walker_q;
			RD_NORTH: rd_addr = walker_q - w12;
			RD_EAST:  rd_addr = walker_q + 12'd1;
			RD_SOUTH: rd_addr = walker_q + w12;
			RD_WEST:  rd_addr = walker_q - 12'd1;
			default:  rd_addr = walker_q;
		endcase
	end

	assign in_grid = (walker13 < area_q);
	assign ok_n = (row_q != '0);
	assign ok_e = (({1'b0, col_q} + 7'd1) < w_c) && ((walker13 + 13'd1) < area_q);
	assign ok_s = ((walker13 + w13) < area_q);
	assign ok_w = (col_q != '0);

	assign cand[0] = in_grid && ok_n && !nb_bits_q[0][mbg_pkg::BIT_VISITED];
	assign cand[1] = in_grid && ok_e && !nb_bits_q[1][mbg_pkg::BIT_VISITED];
	assign cand[2] = in_grid && ok_s && !nb_bits_q[2][mbg_pkg::BIT_VISITED];
	assign cand[3] = in_grid && ok_w && !nb_bits_q[3][mbg_pkg::BIT_VISITED];
	assign n_cand = {2'b0, cand[0]} + {2'b0, cand[1]} + {2'b0, cand[2]} + {2'b0, cand[3]};
	assign have_move = (cand != 4'b0);

	// Since 4 leaves remainder 1 modulo 3, the base-4 digit sum keeps the residue.
	assign pair_sum = {2'b0, rnd_q[1:0]} + {2'b0, rnd_q[3:2]}
		+ {2'b0, rnd_q[5:4]} + {2'b0, rnd_q[7:6]};

	always_comb begin
		case (pair_sum)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: mod3 = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       mod3 = 2'd1;
			4'd2, 4'd5, 4'd8, 4'd11:       mod3 = 2'd2;
			default:                       mod3 = 2'd0;
		endcase
	end

	always_comb begin
		case (n_cand)
			3'd2:    pick_idx = {1'b0, rnd_q[0]};
			3'd3:    pick_idx = mod3;
			3'd4:    pick_idx = rnd_q[1:0];
			default: pick_idx = 2'd0;
		endcase
	end

	// The chosen direction is the candidate whose rank equals pick_idx.
	always_comb begin
		pick = 2'd0;
		seen = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i]) begin
				if (seen == pick_idx) begin
					pick = 2'(i);
				end
				seen = seen + 2'd1;
			end
		end
	end

	always_comb begin
		case ({1'b0, pick_q})
			mbg_pkg::MOVE_NORTH: next_cell = walker_q - w12;
			mbg_pkg::MOVE_EAST:  next_cell = walker_q + 12'd1;
			mbg_pkg::MOVE_SOUTH: next_cell = walker_q + w12;
			default:             next_cell = walker_q - 12'd1;
		endcase
	end

	// Map write port: clearing sweep, current cell update, neighbor wall update.
	always_comb begin
		map_we = 1'b0;
		map_waddr = walker_q;
		map_wdata = '0;
		if (cmd.clr_step) begin
			map_we = 1'b1;
			map_waddr = clr_q;
		end else if (cmd.wr1) begin
			map_we = 1'b1;
			map_wdata = cur_bits_q;
			map_wdata[mbg_pkg::BIT_VISITED] = 1'b1;
			if (have_move && {1'b0, pick} == mbg_pkg::MOVE_EAST) begin
				map_wdata[mbg_pkg::BIT_EAST] = 1'b1;
			end
			if (have_move && {1'b0, pick} == mbg_pkg::MOVE_SOUTH) begin
				map_wdata[mbg_pkg::BIT_SOUTH] = 1'b1;
			end
		end else if (cmd.wr2 && have_move_q) begin
			if ({1'b0, pick_q} == mbg_pkg::MOVE_NORTH) begin
				map_we = 1'b1;
				map_waddr = next_cell;
				map_wdata = nb_bits_q[0];
				map_wdata[mbg_pkg::BIT_SOUTH] = 1'b1;
			end else if ({1'b0, pick_q} == mbg_pkg::MOVE_WEST) begin
				map_we = 1'b1;
				map_waddr = next_cell;
				map_wdata = nb_bits_q[3];
				map_wdata[mbg_pkg::BIT_EAST] = 1'b1;
			end
		end
	end

	assign map_re = cmd.rd_issue || cmd.rep_issue;
	assign map_raddr = cmd.rd_issue ? rd_addr : rep_cell_q;

	assign stk_we = cmd.wr1 && have_move && !depth_q[mbg_pkg::CELL_W];
	assign stk_waddr = depth_q[mbg_pkg::CELL_W-1:0];
	assign stk_wdata = walker_q;
	assign stk_re = cmd.wr2 && !have_move_q && (depth_q != '0);
	assign stk_raddr = stk_waddr - 12'd1;

	mbg_ram #(
		.WIDTH(mbg_pkg::MAP_W),
		.DEPTH(mbg_pkg::MAX_CELLS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	mbg_ram #(
		.WIDTH(mbg_pkg::CELL_W),
		.DEPTH(mbg_pkg::MAX_CELLS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= mbg_pkg::DIM_RESET;
			grid_h_q <= mbg_pkg::DIM_RESET;
			area_q <= '0;
			walker_q <= '0;
			depth_q <= '0;
			active_q <= 1'b0;
			finished_q <= 1'b0;
			coord_ok_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
			div_cnt_q <= '0;
			clr_q <= '0;
			rd_k_q <= '0;
			rd_pend_q <= 1'b0;
			have_move_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			area_q <= area_full[mbg_pkg::DEPTH_W-1:0];
			rd_pend_q <= cmd.rd_issue;

			if (cfg_wen) begin
				case (cfg_index)
					mbg_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_data;
					mbg_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_data;
					default: ;
				endcase
				coord_ok_q <= 1'b0;
			end

			if (cmd.clr_step) begin
				clr_q <= clr_q + 12'd1;
			end

			if (cmd.latch) begin
				rd_k_q <= '0;
			end else if (cmd.rd_issue) begin
				rd_k_q <= rd_k_q + 3'd1;
			end

			if (cmd.start) begin
				walker_q <= '0;
				depth_q <= '0;
				active_q <= 1'b1;
				finished_q <= 1'b0;
				coord_ok_q <= 1'b1;
				row_q <= '0;
				col_q <= '0;
				clr_q <= '0;
			end

			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 4'd1;
				if (div_cnt_q == DIV_LAST) begin
					row_q <= div_quo_n[mbg_pkg::COORD_W-1:0];
					col_q <= div_rem_n;
					coord_ok_q <= 1'b1;
				end
			end

			if (cmd.wr1) begin
				have_move_q <= have_move;
				if (stk_we) begin
					depth_q <= depth_q + 13'd1;
				end
			end

			if (cmd.wr2) begin
				if (have_move_q) begin
					walker_q <= next_cell;
					case ({1'b0, pick_q})
						mbg_pkg::MOVE_NORTH: row_q <= row_q - 6'd1;
						mbg_pkg::MOVE_EAST:  col_q <= col_q + 6'd1;
						mbg_pkg::MOVE_SOUTH: row_q <= row_q + 6'd1;
						default:             col_q <= col_q - 6'd1;
					endcase
				end else if (depth_q != '0) begin
					depth_q <= depth_q - 13'd1;
				end else begin
					active_q <= 1'b0;
					finished_q <= 1'b1;
				end
			end

			if (cmd.pop_load) begin
				walker_q <= stk_rdata;
				coord_ok_q <= 1'b0;
			end

			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			rnd_q <= rnd;
			addr_q <= addr;
		end

		if (cmd.div_start) begin
			div_quo_q <= walker_q;
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			div_quo_q <= div_quo_n;
			div_rem_q <= div_rem_n;
		end

		if (rd_pend_q) begin
			case (rd_slot_q)
				RD_CUR:   cur_bits_q <= map_rdata;
				RD_NORTH: nb_bits_q[0] <= map_rdata;
				RD_EAST:  nb_bits_q[1] <= map_rdata;
				RD_SOUTH: nb_bits_q[2] <= map_rdata;
				default:  nb_bits_q[3] <= map_rdata;
			endcase
		end
		rd_slot_q <= rd_k_q;

		if (cmd.wr1) begin
			pick_q <= pick;
		end

		if (cmd.start) begin
			rep_cell_q <= '0;
			rep_move_q <= mbg_pkg::MOVE_NONE;
			rep_acc_q <= 1'b1;
		end else if (cmd.rep_read) begin
			rep_cell_q <= addr_q;
			rep_move_q <= mbg_pkg::MOVE_NONE;
			rep_acc_q <= 1'b1;
		end else if (cmd.rep_ignore) begin
			rep_cell_q <= walker_q;
			rep_move_q <= mbg_pkg::MOVE_NONE;
			rep_acc_q <= 1'b0;
		end else if (cmd.wr2) begin
			rep_acc_q <= 1'b1;
			if (have_move_q) begin
				rep_cell_q <= next_cell;
				rep_move_q <= {1'b0, pick_q};
			end else begin
				rep_cell_q <= walker_q;
				rep_move_q <= mbg_pkg::MOVE_NONE;
			end
		end else if (cmd.pop_load) begin
			rep_cell_q <= stk_rdata;
		end

		if (cmd.out_load) begin
			cell_res_q <= rep_cell_q;
			move_q <= rep_move_q;
			done_res_q <= finished_q;
			south_open_q <= map_rdata[mbg_pkg::BIT_SOUTH];
			east_open_q <= map_rdata[mbg_pkg::BIT_EAST];
			visited_q <= map_rdata[mbg_pkg::BIT_VISITED];
			accepted_q <= rep_acc_q;
		end
	end

	assign out_free = !res_valid_q || !res_stall;

	assign stat.func = func_q;
	assign stat.active = active_q;
	assign stat.coord_ok = coord_ok_q;
	assign stat.in_grid = in_grid;
	assign stat.div_last = (div_cnt_q == DIV_LAST);
	assign stat.rd_last = (rd_k_q == RD_WEST);
	assign stat.clr_last = (clr_q == '1);
	assign stat.pop_next = !have_move_q && (depth_q != '0);
	assign stat.out_free = out_free;

	assign res_valid = res_valid_q;
	assign cell_res = cell_res_q;
	assign move = move_q;
	assign done_res = done_res_q;
	assign south_open = south_open_q;
	assign east_open = east_open_q;
	assign visited = visited_q;
	assign accepted = accepted_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= mbg_pkg::STACK_FULL)
		else $error("backtrack stack depth beyond its capacity");

	a_active_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(active_q && finished_q))
		else $error("walk is active and complete at once");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		coord_ok_q |-> ({1'b0, col_q} < w_c))
		else $error("cached column lies outside the grid width");
`endif

endmodule

// ----- hdl/maze_backtracker_generator.sv -----
// Read items and ignored steps: decode, report, output; next item only after the result.
// Walk step: five map reads and two write phases, plus a stack pop on a backtrack; a step
// after a backtrack or a size write first rederives row and column.
// Start: clears all 4096 map entries one per cycle, then reports cell 0.
// Reset is asynchronous, active low; after it the map is cleared in a sweep of all 4096
// entries during which item_stall stays high. Configuration writes are taken at any time.
module maze_backtracker_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [mbg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbg_pkg::DIM_W-1:0]       cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [1:0]                      func,
	input  logic [7:0]                      rnd,
	input  logic [mbg_pkg::CELL_W-1:0]      addr,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [mbg_pkg::CELL_W-1:0]      cell_res,
	output logic [2:0]                      move,
	output logic                            done_res,
	output logic                            south_open,
	output logic                            east_open,
	output logic                            visited,
	output logic                            accepted
);

	mbg_pkg::cmd_t  cmd;
	mbg_pkg::stat_t stat;

	mbg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	mbg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.rnd        (rnd),
		.addr       (addr),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.cell_res   (cell_res),
		.move       (move),
		.done_res   (done_res),
		.south_open (south_open),
		.east_open  (east_open),
		.visited    (visited),
		.accepted   (accepted),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule
